[hdl/ipc_pkg.sv]
// Shared types and constants of the infrared pulse capture block.
package ipc_pkg;

  // Field widths of one input beat, one result beat and one register write.
  localparam int unsigned StampW    = 16;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 2;

  // Entries of the result queue; two of them are kept free for one input beat.
  localparam int unsigned QueueDepth = 4;

  // Register reset values.
  localparam logic [15:0] FirstEdgeTimeoutRst = 16'd10000;
  localparam logic [15:0] GapTimeoutRst       = 16'd100;
  localparam logic [7:0]  MaxEdgesRst         = 8'd200;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CfgFirstEdgeTimeout = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgGapTimeout       = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgMaxEdges         = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  typedef enum logic {
    KIND_INTERVAL = 1'b0,
    KIND_DONE     = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_TOO_MANY = 2'd1,
    ERR_NO_EDGE  = 2'd2
  } err_e;

  typedef struct packed {
    kind_e                  kind;
    logic [IntervalW-1:0]   interval;
    logic [CountW-1:0]      interval_count;
    err_e                   scan_error;
    logic                   arm_rising;
    logic                   last;
  } result_t;

  // Results produced by one accepted input beat, in delivery order.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

[hdl/ir_pulse_capture.sv]
// Top level of the infrared pulse capture block.
//
// This block learns the edge timing of one infrared remote burst. A start
// beat opens a scan armed for a falling edge; each edge beat carries the
// timer stamp of that edge, and after the first edge the block reports the
// gap to the previous edge (modulo 2^min(STAMP_BITS,16)) and the polarity
// to arm next. Tick beats count milliseconds of silence, and the scan ends
// when the silence reaches first_edge_timeout before any edge or gap_timeout
// after one, or when the edge count reaches max_edges. A scan finished result
// then gives the interval count and an error code. Every input beat is
// handled in the cycle it is accepted, so the block takes one beat per clock;
// one beat can cause up to two result beats, which wait in a four-entry
// result queue. The input is stalled whenever that queue has fewer than two
// free entries, so a sustained run of beats that each cause two results is
// limited by the output side to one result per cycle. Configuration writes
// take effect at the next edge and should only be issued while idle.
module ir_pulse_capture #(
  parameter int unsigned STAMP_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipc_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [ipc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic [ipc_pkg::StampW-1:0]     timestamp_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           kind_o,
  output logic [ipc_pkg::IntervalW-1:0]  interval_o,
  output logic [ipc_pkg::CountW-1:0]     interval_count_o,
  output logic [1:0]                     scan_error_o,
  output logic                           arm_rising_o,
  output logic                           last_o
);

  logic             room;
  logic             accept;
  ipc_pkg::push_t   push;
  ipc_pkg::result_t head;

  // The stall depends only on the queue fill, never on the valid.
  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  ipc_core #(
    .STAMP_BITS(STAMP_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .timestamp_i(timestamp_i),
    .push_o     (push)
  );

  ipc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (!out_stall_i),
    .room_o (room),
    .valid_o(out_valid_o),
    .head_o (head)
  );

  // The result beat is presented straight from the queue head.
  assign kind_o           = head.kind;
  assign interval_o       = head.interval;
  assign interval_count_o = head.interval_count;
  assign scan_error_o     = head.scan_error;
  assign arm_rising_o     = head.arm_rising;
  assign last_o           = head.last;

endmodule

[hdl/ipc_core.sv]
// Scan state, configuration registers and result generation of the pulse capture block.
module ipc_core #(
  parameter int unsigned STAMP_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipc_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [ipc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           accept_i,
  input  logic [1:0]                     cmd_i,
  input  logic [ipc_pkg::StampW-1:0]     timestamp_i,
  output ipc_pkg::push_t                 push_o
);

  // Stamps arrive 16 bits wide, so only the lower of the two widths matters.
  localparam int unsigned EffW =
    (STAMP_BITS < ipc_pkg::StampW) ? STAMP_BITS : ipc_pkg::StampW;

  logic [15:0] first_to_q, gap_to_q;
  logic [7:0]  max_edges_q;

  logic                 scanning_q, scanning_d;
  logic [15:0]          silence_q, silence_d;
  logic [15:0]          active_to_q, active_to_d;
  logic [7:0]           edges_q, edges_d;
  logic [EffW-1:0]      prev_q, prev_d;
  logic                 armed_q, armed_d;

  logic [15:0]          silence_inc;
  logic [EffW-1:0]      gap;
  logic                 have_int, have_done;
  ipc_pkg::err_e        done_err;
  logic [7:0]           done_edges;
  ipc_pkg::result_t     int_res, done_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_to_q  <= ipc_pkg::FirstEdgeTimeoutRst;
      gap_to_q    <= ipc_pkg::GapTimeoutRst;
      max_edges_q <= ipc_pkg::MaxEdgesRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ipc_pkg::CfgFirstEdgeTimeout: first_to_q  <= cfg_data_i;
        ipc_pkg::CfgGapTimeout:       gap_to_q    <= cfg_data_i;
        ipc_pkg::CfgMaxEdges:         max_edges_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign silence_inc = (silence_q != 16'hFFFF) ? silence_q + 16'd1 : silence_q;
  assign gap         = timestamp_i[EffW-1:0] - prev_q;

  always_comb begin
    scanning_d  = scanning_q;
    silence_d   = silence_q;
    active_to_d = active_to_q;
    edges_d     = edges_q;
    prev_d      = prev_q;
    armed_d     = armed_q;
    have_int    = 1'b0;
    have_done   = 1'b0;
    done_err    = ipc_pkg::ERR_OK;
    done_edges  = edges_q;
    case (ipc_pkg::cmd_e'(cmd_i))
      ipc_pkg::CMD_START: begin
        scanning_d  = 1'b1;
        silence_d   = '0;
        active_to_d = first_to_q;
        edges_d     = '0;
        prev_d      = '0;
        armed_d     = 1'b0;
      end
      ipc_pkg::CMD_TICK: begin
        if (scanning_q) begin
          silence_d = silence_inc;
          if (silence_inc >= active_to_q) begin
            have_done  = 1'b1;
            scanning_d = 1'b0;
          end
        end
      end
      ipc_pkg::CMD_EDGE: begin
        if (scanning_q) begin
          silence_d   = '0;
          active_to_d = gap_to_q;
          armed_d     = !armed_q;
          have_int    = (edges_q != 8'd0);
          prev_d      = timestamp_i[EffW-1:0];
          edges_d     = (edges_q != 8'hFF) ? edges_q + 8'd1 : edges_q;
          done_edges  = edges_d;
          if (edges_d >= max_edges_q) begin
            have_done  = 1'b1;
            done_err   = ipc_pkg::ERR_TOO_MANY;
            scanning_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    int_res                = '0;
    int_res.kind           = ipc_pkg::KIND_INTERVAL;
    int_res.interval       = ipc_pkg::IntervalW'(gap);
    int_res.scan_error     = ipc_pkg::ERR_OK;
    int_res.arm_rising     = armed_d;
    int_res.last           = !have_done;

    done_res               = '0;
    done_res.kind          = ipc_pkg::KIND_DONE;
    done_res.interval_count = (done_edges != 8'd0) ? done_edges - 8'd1 : 8'd0;
    done_res.scan_error    = (done_edges == 8'd0) ? ipc_pkg::ERR_NO_EDGE : done_err;
    done_res.last          = 1'b1;

    push_o.num    = {1'b0, have_int} + {1'b0, have_done};
    push_o.first  = have_int ? int_res : done_res;
    push_o.second = done_res;
    if (!accept_i) begin
      push_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanning_q  <= 1'b0;
      silence_q   <= '0;
      active_to_q <= '0;
      edges_q     <= '0;
      prev_q      <= '0;
      armed_q     <= 1'b0;
    end else if (accept_i) begin
      scanning_q  <= scanning_d;
      silence_q   <= silence_d;
      active_to_q <= active_to_d;
      edges_q     <= edges_d;
      prev_q      <= prev_d;
      armed_q     <= armed_d;
    end
  end

endmodule

[hdl/ipc_queue.sv]
// Small result queue that takes up to two results per cycle and hands out one while the output is not stalled.
module ipc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipc_pkg::push_t    push_i,
  input  logic              pop_i,
  output logic              room_o,
  output logic              valid_o,
  output ipc_pkg::result_t  head_o
);

  localparam int unsigned PtrW = $clog2(ipc_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(ipc_pkg::QueueDepth + 1);

  ipc_pkg::result_t entry_q [ipc_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic [PtrW-1:0]  wr_next;
  logic             pop;

  assign wr_next = wr_ptr_q + PtrW'(1);
  assign pop     = pop_i && (count_q != '0);
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  // Room for the two results one input beat can cause at most.
  assign room_o  = (count_q <= CntW'(ipc_pkg::QueueDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      entry_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.num);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_i.num) - CntW'(pop);
    end
  end

endmodule

[dv/ir_pulse_capture_tb.sv]
// Testbench of the infrared pulse capture block: directed scans, then random bursts.
`timescale 1ns / 1ps

module ir_pulse_capture_tb;

  // The one command code that the block does not use.
  localparam logic [1:0] CmdUnused = 2'd3;
  // Random beats to send after the directed tests.
  localparam int unsigned RandomBeats = 900;
  // Cycles with no beat, no result and no register write before giving up.
  localparam int unsigned QuietLimit = 1000;
  // Cycles allowed for the block to settle after the last expected result.
  localparam int unsigned SettleCycles = 8;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i = 1'b0;
  logic [ipc_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [ipc_pkg::CfgDataW-1:0]  cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    cmd_i = ipc_pkg::CMD_TICK;
  logic [ipc_pkg::StampW-1:0]    timestamp_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          kind_o;
  logic [ipc_pkg::IntervalW-1:0] interval_o;
  logic [ipc_pkg::CountW-1:0]    interval_count_o;
  logic [1:0]                    scan_error_o;
  logic                          arm_rising_o;
  logic                          last_o;

  ir_pulse_capture u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .timestamp_i      (timestamp_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .interval_o       (interval_o),
    .interval_count_o (interval_count_o),
    .scan_error_o     (scan_error_o),
    .arm_rising_o     (arm_rising_o),
    .last_o           (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Expected scan state, mirrored beat by beat. The register copies follow
  // the write port, so they always match what the block was told.
  logic [15:0]                cfg_first_timeout = ipc_pkg::FirstEdgeTimeoutRst;
  logic [15:0]                cfg_gap_timeout   = ipc_pkg::GapTimeoutRst;
  logic [7:0]                 cfg_edge_limit    = ipc_pkg::MaxEdgesRst;
  logic                       scan_open         = 1'b0;
  logic [15:0]                silence_count     = '0;
  logic [15:0]                silence_limit     = '0;
  logic [7:0]                 edge_count        = '0;
  logic [ipc_pkg::StampW-1:0] prior_stamp       = '0;
  logic                       arm_rise          = 1'b0;

  // Result beats the block still owes, oldest first.
  ipc_pkg::result_t pending_results[$];

  int unsigned mismatches   = 0;
  int unsigned beats_sent   = 0;
  int unsigned quiet_cycles = 0;

  // Stimulus side knobs: sender gaps, receiver stalls, and the gap timeout
  // last written, which tells a burst how many ticks close the scan.
  bit          idle_on     = 1'b1;
  bit          stall_on    = 1'b1;
  logic [15:0] gap_setting = ipc_pkg::GapTimeoutRst;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Builds the scan finished result and closes the scan. A scan that saw no
  // edge at all always reports that, whatever ended it.
  function automatic ipc_pkg::result_t close_scan(input ipc_pkg::err_e cause);
    ipc_pkg::result_t r;
    r = '0;
    r.kind = ipc_pkg::KIND_DONE;
    r.interval_count = (edge_count != 0) ? edge_count - 8'd1 : 8'd0;
    r.scan_error = (edge_count == 0) ? ipc_pkg::ERR_NO_EDGE : cause;
    scan_open = 1'b0;
    return r;
  endfunction

  // Applies one accepted beat to the expected state and queues the results
  // that it causes; the final one of them carries the last flag.
  function automatic void advance_scan(input logic [1:0] cmd,
                                       input logic [ipc_pkg::StampW-1:0] stamp);
    ipc_pkg::result_t made[$];
    ipc_pkg::result_t r;
    case (cmd)
      ipc_pkg::CMD_START: begin
        // A start while scanning drops the old scan without a result.
        scan_open = 1'b1;
        silence_count = '0;
        silence_limit = cfg_first_timeout;
        edge_count = '0;
        prior_stamp = '0;
        arm_rise = 1'b0;
      end
      ipc_pkg::CMD_TICK: begin
        if (scan_open) begin
          // Saturating, so even the largest timeout is reached.
          if (silence_count != 16'hFFFF) begin
            silence_count++;
          end
          if (silence_count >= silence_limit) begin
            made.push_back(close_scan(ipc_pkg::ERR_OK));
          end
        end
      end
      ipc_pkg::CMD_EDGE: begin
        if (scan_open) begin
          silence_count = '0;
          silence_limit = cfg_gap_timeout;
          arm_rise = ~arm_rise;
          // The first edge only sets the reference stamp.
          if (edge_count != 0) begin
            r = '0;
            r.kind = ipc_pkg::KIND_INTERVAL;
            r.interval = stamp - prior_stamp;
            r.arm_rising = arm_rise;
            made.push_back(r);
          end
          prior_stamp = stamp;
          if (edge_count != 8'hFF) begin
            edge_count++;
          end
          if (edge_count >= cfg_edge_limit) begin
            made.push_back(close_scan(ipc_pkg::ERR_TOO_MANY));
          end
        end
      end
      default: ;
    endcase
    if (made.size() != 0) begin
      made[made.size() - 1].last = 1'b1;
    end
    foreach (made[i]) begin
      pending_results.push_back(made[i]);
    end
  endfunction

  // One process sees every handshake of a clock edge, in a fixed order:
  // the register write, then the input beat, then the result beat. That way
  // a result can never be checked before the beat that causes it is mirrored.
  always @(posedge clk_i) begin
    ipc_pkg::result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ipc_pkg::CfgFirstEdgeTimeout: cfg_first_timeout = cfg_data_i;
          ipc_pkg::CfgGapTimeout:       cfg_gap_timeout = cfg_data_i;
          ipc_pkg::CfgMaxEdges:         cfg_edge_limit = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        advance_scan(cmd_i, timestamp_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result beat with no result expected");
        end else begin
          want = pending_results.pop_front();
          check_field("kind", kind_o, want.kind);
          check_field("interval", interval_o, want.interval);
          check_field("interval_count", interval_count_o, want.interval_count);
          check_field("scan_error", scan_error_o, want.scan_error);
          check_field("arm_rising", arm_rising_o, want.arm_rising);
          check_field("last", last_o, want.last);
        end
      end
    end
  end

  // The receiver stalls at random, about 30 percent of the time, while stalls are on.
  always @(posedge clk_i) begin
    out_stall_i <= stall_on && ($urandom_range(99) < 30);
  end

  // Watchdog: a run that stops moving is a failure, not a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("[ir_pulse_capture] ERROR");
      $finish;
    end
  end

  // Sends one input beat and returns at the edge that accepts it. Valid is
  // left high so that back-to-back beats need no second assignment.
  task automatic send_beat(input logic [1:0] cmd, input logic [ipc_pkg::StampW-1:0] stamp);
    if (idle_on && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    timestamp_i <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // Stops sending, waits for every owed result, then lets the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all three registers, one per clock, while the block is idle.
  task automatic load_settings(input logic [15:0] first_timeout,
                               input logic [15:0] gap_timeout,
                               input logic [7:0] edge_limit);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ipc_pkg::CfgFirstEdgeTimeout;
    cfg_data_i  <= first_timeout;
    @(posedge clk_i);
    cfg_index_i <= ipc_pkg::CfgGapTimeout;
    cfg_data_i  <= gap_timeout;
    @(posedge clk_i);
    cfg_index_i <= ipc_pkg::CfgMaxEdges;
    cfg_data_i  <= {8'd0, edge_limit};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gap_setting = gap_timeout;
  endtask

  // Edges, ticks and the unused code are all dropped while no scan is open.
  task automatic test_ignored_beats();
    send_beat(ipc_pkg::CMD_TICK, 16'hFFFF);
    send_beat(ipc_pkg::CMD_EDGE, 16'hFFFF);
    send_beat(CmdUnused, 16'hFFFF);
  endtask

  // Reset values of the registers: the scan closes after 100 silent ticks.
  task automatic test_reset_values();
    send_beat(ipc_pkg::CMD_START, 16'hFFFF);
    send_beat(ipc_pkg::CMD_EDGE, 16'h0010);
    send_beat(ipc_pkg::CMD_EDGE, 16'h0110);
    repeat (100) send_beat(ipc_pkg::CMD_TICK, 16'h0000);
  endtask

  // Intervals across the stamp wrap, the largest and a zero interval, and
  // the polarity flipping on each edge.
  task automatic test_stamp_wrap();
    load_settings(16'd3, 16'd2, 8'd200);
    send_beat(ipc_pkg::CMD_START, 16'h0000);
    send_beat(ipc_pkg::CMD_EDGE, 16'hFFFF);
    send_beat(ipc_pkg::CMD_EDGE, 16'h0000);
    send_beat(ipc_pkg::CMD_EDGE, 16'hFFFF);
    send_beat(ipc_pkg::CMD_EDGE, 16'hFFFF);
    send_beat(ipc_pkg::CMD_TICK, 16'hFFFF);
    send_beat(ipc_pkg::CMD_TICK, 16'h0000);
  endtask

  // A start in the middle of a scan drops it; the stamp of a start is unused.
  task automatic test_restart();
    send_beat(ipc_pkg::CMD_START, 16'h1234);
    send_beat(ipc_pkg::CMD_EDGE, 16'h1000);
    send_beat(ipc_pkg::CMD_EDGE, 16'h1100);
    send_beat(ipc_pkg::CMD_START, 16'h5555);
    send_beat(ipc_pkg::CMD_EDGE, 16'h2000);
    send_beat(ipc_pkg::CMD_EDGE, 16'h2345);
    send_beat(ipc_pkg::CMD_TICK, 16'h0000);
    send_beat(ipc_pkg::CMD_TICK, 16'h0000);
  endtask

  // Edge limits of zero and one end the scan on the first edge; a limit of
  // two gives one interval followed by the too-many result.
  task automatic test_edge_limit();
    load_settings(16'd5, 16'd5, 8'd0);
    send_beat(ipc_pkg::CMD_START, 16'h0000);
    send_beat(ipc_pkg::CMD_EDGE, 16'h00AA);
    load_settings(16'd5, 16'd5, 8'd1);
    send_beat(ipc_pkg::CMD_START, 16'h0000);
    send_beat(ipc_pkg::CMD_EDGE, 16'h0055);
    load_settings(16'd5, 16'd5, 8'd2);
    send_beat(ipc_pkg::CMD_START, 16'h0000);
    send_beat(ipc_pkg::CMD_EDGE, 16'h8000);
    send_beat(ipc_pkg::CMD_EDGE, 16'h7FFF);
  endtask

  // Timeouts of zero and one close the scan on its first tick; one scan at zero sees an edge first.
  task automatic test_short_timeouts();
    load_settings(16'd0, 16'd0, 8'd255);
    send_beat(ipc_pkg::CMD_START, 16'h0000);
    send_beat(ipc_pkg::CMD_TICK, 16'h0000);
    send_beat(ipc_pkg::CMD_START, 16'h0000);
    send_beat(ipc_pkg::CMD_EDGE, 16'h0001);
    send_beat(ipc_pkg::CMD_TICK, 16'h0000);
    load_settings(16'd1, 16'd1, 8'd255);
    send_beat(ipc_pkg::CMD_START, 16'h0000);
    send_beat(ipc_pkg::CMD_TICK, 16'h0000);
  endtask

  // A long first edge timeout: the silence counter must climb all the way to it.
  task automatic test_silence_ceiling();
    load_settings(16'd200, 16'd1, 8'd255);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    send_beat(ipc_pkg::CMD_START, 16'h0000);
    repeat (200) send_beat(ipc_pkg::CMD_TICK, 16'h0000);
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // One well-formed burst with random stamps: start, a run of edges with a
  // few ticks and stray beats among them, and often the ticks that close it.
  task automatic send_burst();
    logic [ipc_pkg::StampW-1:0] stamp;
    int unsigned                edges;
    stamp = 16'($urandom);
    edges = $urandom_range(1, 14);
    send_beat(ipc_pkg::CMD_START, 16'($urandom));
    repeat (edges) begin
      if ($urandom_range(9) == 0) begin
        send_beat(2'($urandom_range(0, 3)), 16'($urandom));
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 2)) send_beat(ipc_pkg::CMD_TICK, 16'($urandom));
      end
      stamp = $urandom_range(1) ? stamp + 16'($urandom_range(1, 4000)) : 16'($urandom);
      send_beat(ipc_pkg::CMD_EDGE, stamp);
    end
    if (gap_setting <= 40 && $urandom_range(3) != 0) begin
      repeat (gap_setting) send_beat(ipc_pkg::CMD_TICK, 16'($urandom));
    end
  endtask

  // Phases of random bursts, each under its own register settings. One kind
  // of phase runs with no sender gaps and no receiver stalls at all.
  task automatic test_random_bursts();
    int unsigned first_beat;
    int unsigned phase;
    first_beat = beats_sent;
    phase = 0;
    while (beats_sent - first_beat < RandomBeats) begin
      case (phase % 6)
        0: load_settings(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                         8'($urandom_range(2, 16)));
        1: load_settings(16'd1, 16'd1, 8'd2);
        2: load_settings(16'd60000, 16'd60000, 8'd255);
        3: load_settings(16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
                         8'($urandom_range(2, 255)));
        4: load_settings(16'($urandom_range(0, 3)), 16'($urandom_range(0, 5)),
                         8'($urandom_range(0, 20)));
        default: load_settings(16'($urandom), 16'($urandom_range(1, 40)), 8'($urandom));
      endcase
      idle_on  = (phase % 6 != 3);
      stall_on = (phase % 6 != 3);
      repeat (12) send_burst();
      phase++;
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_beats();
    test_reset_values();
    test_stamp_wrap();
    test_restart();
    test_edge_limit();
    test_short_timeouts();
    test_silence_ceiling();
    test_random_bursts();

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      flag_mismatch("results still expected at the end of the run");
    end
    if (mismatches == 0) begin
      $display("[ir_pulse_capture] OK");
    end else begin
      $display("[ir_pulse_capture] ERROR");
    end
    $finish;
  end

endmodule
